// ===== rtl/swa_pkg.sv =====
`default_nettype none

package swa_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int WINDOW_RESET    = 4;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIVIDE,
        B_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/swa_front.sv =====
`default_nettype none

module swa_front #(
    parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
    localparam int PTR_W = $clog2(MAX_WINDOW),
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = SAMPLE_BITS + PTR_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [swa_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [SAMPLE_BITS-1:0]       i_sample,
    output logic                              o_push,
    output logic [SUM_W-1:0]                  o_sum,
    input  wire logic                         i_push_ready,
    output logic [CNT_W-1:0]                  o_window
);

    localparam int CMP_W     = ((CNT_W > swa_pkg::CFG_BITS) ? CNT_W : swa_pkg::CFG_BITS) + 1;
    localparam int RESET_WIN = (swa_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                     : swa_pkg::WINDOW_RESET;

    swa_pkg::t_front_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [CNT_W-1:0]       r_win, n_win;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [PTR_W-1:0]       r_ptr, n_ptr;

    logic             accept;
    logic             step_done;
    logic             full;
    logic             emit;
    logic [CMP_W-1:0] cfg_ext;
    logic [PTR_W:0]   ptr_inc;
    logic [SUM_W-1:0] old_ext;
    logic [SUM_W-1:0] new_ext;

    // window size clamp: zero reads as one, oversize saturates
    always_comb begin
        cfg_ext = CMP_W'(i_cfg_wdata);
        if (cfg_ext == '0) begin
            n_win = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
            n_win = CNT_W'(MAX_WINDOW);
        end else begin
            n_win = CNT_W'(cfg_ext);
        end
    end

    always_comb begin
        full    = (r_fill == r_win);
        n_fill  = full ? r_fill : r_fill + 1'b1;
        emit    = (n_fill == r_win);
        ptr_inc = {1'b0, r_ptr} + 1'b1;
        n_ptr   = (CMP_W'(ptr_inc) >= CMP_W'(r_win)) ? '0 : ptr_inc[PTR_W-1:0];
        old_ext = full ? {{PTR_W{r_rd[SAMPLE_BITS-1]}}, r_rd} : '0;
        new_ext = {{PTR_W{r_sample[SAMPLE_BITS-1]}}, r_sample};
        n_sum   = r_sum - old_ext + new_ext;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swa_pkg::F_IDLE: begin
                if (i_valid) begin
                    n_state = swa_pkg::F_UPDATE;
                end
            end
            swa_pkg::F_UPDATE: begin
                if (!emit || i_push_ready) begin
                    n_state = swa_pkg::F_IDLE;
                end
            end
            default: n_state = swa_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_push    = 1'b0;
        step_done = 1'b0;
        case (r_state)
            swa_pkg::F_IDLE: begin
                o_ready = 1'b1;
            end
            swa_pkg::F_UPDATE: begin
                o_push    = emit;
                step_done = !emit || i_push_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign accept   = i_valid && o_ready;
    assign o_sum    = n_sum;
    assign o_window = r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swa_pkg::F_IDLE;
            r_win   <= CNT_W'(RESET_WIN);
            r_sum   <= '0;
            r_fill  <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win  <= n_win;
                r_sum  <= '0;
                r_fill <= '0;
                r_ptr  <= '0;
            end else if (step_done) begin
                r_sum  <= n_sum;
                r_fill <= n_fill;
                r_ptr  <= n_ptr;
            end
        end
    end

    // ring store; the oldest slot is read every cycle, so it is ready
    // in the cycle after the transaction is taken
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_ptr];
        if (step_done) begin
            r_mem[r_ptr] <= r_sample;
        end
        if (accept) begin
            r_sample <= i_sample;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swa_queue.sv =====
`default_nettype none

module swa_queue #(
    parameter int WIDTH = 22,
    parameter int DEPTH = swa_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_push_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_data       = r_buf[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swa_back.sv =====
`default_nettype none

module swa_back #(
    parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
    localparam int PTR_W = $clog2(MAX_WINDOW),
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = SAMPLE_BITS + PTR_W
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [SUM_W-1:0]       i_sum,
    output logic                        o_pop,
    input  wire logic [CNT_W-1:0]       i_window,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_average
);

    localparam int REM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(SUM_W);

    swa_pkg::t_back_state r_state, n_state;

    logic [SUM_W-1:0]       r_quo;
    logic [REM_W-1:0]       r_rem;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_avg;

    logic             load_out;
    logic [REM_W-1:0] rem_sh;
    logic             fits;
    logic [REM_W-1:0] rem_new;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] quo_signed;

    // restoring division of |sum|, one quotient bit per cycle
    always_comb begin
        rem_sh     = {r_rem[REM_W-2:0], r_quo[SUM_W-1]};
        fits       = (rem_sh >= REM_W'(i_window));
        rem_new    = fits ? rem_sh - REM_W'(i_window) : rem_sh;
        mag        = i_sum[SUM_W-1] ? -i_sum : i_sum;
        quo_signed = r_neg ? -r_quo : r_quo;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swa_pkg::B_IDLE: begin
                if (i_valid) begin
                    n_state = swa_pkg::B_DIVIDE;
                end
            end
            swa_pkg::B_DIVIDE: begin
                if (r_step == '0) begin
                    n_state = swa_pkg::B_DONE;
                end
            end
            swa_pkg::B_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = swa_pkg::B_IDLE;
                end
            end
            default: n_state = swa_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            swa_pkg::B_IDLE: begin
                o_pop = i_valid;
            end
            swa_pkg::B_DONE: begin
                load_out = !r_out_valid || i_ready;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swa_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo  <= mag;
            r_rem  <= '0;
            r_neg  <= i_sum[SUM_W-1];
            r_step <= STEP_W'(SUM_W - 1);
        end else if (r_state == swa_pkg::B_DIVIDE) begin
            r_quo  <= {r_quo[SUM_W-2:0], fits};
            r_rem  <= rem_new;
            r_step <= r_step - 1'b1;
        end
        if (load_out) begin
            r_avg <= quo_signed[SAMPLE_BITS-1:0];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_avg;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_average.sv =====
// Moving average over the last N signed samples.
//
// Slave stream: one sample per transaction in i_s_tdata. Master stream: one
// average per transaction in o_m_tdata, the window sum divided by N and
// truncated toward zero. N comes from i_cfg_wdata when i_cfg_we is high;
// 0 is taken as 1, values above MAX_WINDOW saturate, and every write empties
// the window. Write it only while no sample is in flight.
// After reset or a write, the first N-1 samples only fill the window.
//
// The front end takes one sample at a time (oldest-slot read from the ring
// store, then sum update) and hands the sum to a 2-entry queue, holding it
// while the queue is full. The back end divides with one quotient bit per cycle
// and pops the next sum only once the last average is in the result register.
// Reset (i_rst_n low, synchronous) empties the window and sets N to 4; the
// ring store needs no clearing. A stalled receiver holds the result register;
// the queue fills and then o_s_tready stays low.
`default_nettype none

module sliding_window_average #(
    parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [swa_pkg::CFG_BITS-1:0] i_cfg_wdata,   // window_size
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [DATA_W-1:0]            i_s_tdata,     // sample
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [DATA_W-1:0]                 o_m_tdata      // average
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + PTR_W;

    logic                   push, push_ready;
    logic [SUM_W-1:0]       push_sum;
    logic                   q_valid, q_pop;
    logic [SUM_W-1:0]       q_sum;
    logic [CNT_W-1:0]       window;
    logic [SAMPLE_BITS-1:0] average;

    swa_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_sample     (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_push       (push),
        .o_sum        (push_sum),
        .i_push_ready (push_ready),
        .o_window     (window)
    );

    swa_queue #(
        .WIDTH (SUM_W),
        .DEPTH (swa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (push_sum),
        .o_push_ready (push_ready),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_data       (q_sum)
    );

    swa_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_sum     (q_sum),
        .o_pop     (q_pop),
        .i_window  (window),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_average (average)
    );

    assign o_m_tdata = DATA_W'(average);

endmodule

`default_nettype wire

// ===== rtl/swa_checker.sv =====
`default_nettype none

module swa_checker #(
    parameter int DATA_W = 16
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [DATA_W-1:0] o_m_tdata
);

    // reset leaves the input side open and nothing on the output
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready && !o_m_tvalid)
        else $error("state after reset wrong");

    // one sample at a time: ready drops after each transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second sample taken before the first was stored");

    // a stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

endmodule

bind sliding_window_average swa_checker #(
    .DATA_W (DATA_W)
) u_swa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

    localparam int WIN_MAX      = swa_pkg::MAX_WINDOW_DEF;
    localparam int SMP_W        = swa_pkg::SAMPLE_BITS_DEF;
    localparam int CFG_W        = swa_pkg::CFG_BITS;
    localparam int SUM_W        = 22;
    localparam int SLOT_W       = $clog2(WIN_MAX);
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int TARGET_ITEMS = 700;

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [SMP_W-1:0]   s_tdata   = '0;   // sample
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [SMP_W-1:0]   m_tdata;          // average

    sliding_window_average i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // window predictor state
    logic signed [SMP_W-1:0] ring_buf [WIN_MAX];
    logic signed [SUM_W-1:0] acc_sum;
    logic [CFG_W-1:0]        held_count;
    logic [SLOT_W-1:0]       next_slot;
    logic [CFG_W-1:0]        win_len;

    logic signed [SMP_W-1:0] pending_samples [$];
    logic [SMP_W-1:0]        expected_avgs [$];

    logic gaps_on      = 1'b1;
    logic hold_request = 1'b0;
    int   hold_cnt     = 0;
    int   idle_cycles  = 0;
    int   mismatches   = 0;
    int   samples_sent = 0;
    int   avgs_checked = 0;
    int   windows_set  = 0;

    function automatic void set_window(input logic [CFG_W-1:0] v);
        if (v == 0)
            win_len = CFG_W'(1);
        else if (v > WIN_MAX)
            win_len = CFG_W'(WIN_MAX);
        else
            win_len = v;
        acc_sum    = '0;
        held_count = '0;
        next_slot  = '0;
    endfunction

    function automatic void advance_window(input logic signed [SMP_W-1:0] smp);
        logic signed [SUM_W-1:0] quot;
        if (held_count >= win_len)
            acc_sum = acc_sum - ring_buf[next_slot];
        else
            held_count = held_count + 1'b1;
        acc_sum = acc_sum + smp;
        ring_buf[next_slot] = smp;
        if ({1'b0, next_slot} + 7'd1 >= win_len)
            next_slot = '0;
        else
            next_slot = next_slot + 1'b1;
        if (held_count >= win_len) begin
            // signed divide truncates toward zero
            quot = acc_sum / $signed({1'b0, win_len});
            expected_avgs.push_back(quot[SMP_W-1:0]);
        end
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            1, 2: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return $signed(16'($urandom_range(0, 65535)));
        endcase
    endfunction

    always @(posedge i_clk) begin : sample_driver
        logic offer;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_window(s_tdata);
                samples_sent++;
            end
            if (!s_tvalid || s_tready) begin
                offer = pending_samples.size() != 0 &&
                        !(gaps_on && $urandom_range(0, 99) < 12);
                if (offer) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : hold_off
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_request)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin : average_monitor
        logic [SMP_W-1:0] want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                avgs_checked++;
                if (expected_avgs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: average %0d arrived with none expected",
                                 $realtime, $signed(m_tdata));
                end else begin
                    want = expected_avgs.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: average expected %0d (0x%h), got %0d (0x%h)",
                                     $realtime, $signed(want), want,
                                     $signed(m_tdata), m_tdata);
                    end
                end
            end
            m_tready <= (hold_cnt == 0) && !(gaps_on && $urandom_range(0, 99) < 12);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d averages outstanding",
                     idle_cycles, expected_avgs.size());
            $display("** sliding_window_average: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // wait until every sample is in and every average out, then let the
    // front end finish any sample that gives no average
    task automatic settle();
        while (pending_samples.size() != 0 || s_tvalid || expected_avgs.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        settle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        set_window(v);
        windows_set++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic signed [SMP_W-1:0] fill_a [] = '{
            16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            -16'sd1, 16'sd0, 16'sd0, 16'sd0,
            -16'sd6, 16'sd3, 16'sd1, 16'sd9
        };
        logic signed [SMP_W-1:0] fill_b [] = '{
            16'sh8000, 16'sh7FFF, -16'sd1, 16'sd0, 16'sd1
        };
        logic signed [SMP_W-1:0] fixed;
        int items_planned;
        int phase;
        int win;
        int eff;
        int span;
        int mode;

        set_window(CFG_W'(swa_pkg::WINDOW_RESET));
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window size, extremes and truncation of negative sums
        foreach (fill_a[i]) pending_samples.push_back(fill_a[i]);
        // zero written means a window of one
        write_window('0);
        foreach (fill_b[i]) pending_samples.push_back(fill_b[i]);
        // window left part-filled, then rewritten
        write_window(7'd5);
        pending_samples.push_back(16'sd100);
        pending_samples.push_back(-16'sd100);
        pending_samples.push_back(16'sd7);
        write_window(7'd3);
        pending_samples.push_back(-16'sd7);
        pending_samples.push_back(16'sd2);
        pending_samples.push_back(16'sd1);
        items_planned = fill_a.size() + fill_b.size() + 6;

        phase = 0;
        while (items_planned < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0: win = $urandom_range(0, 1);
                1: win = $urandom_range(64, 127);
                default: win = $urandom_range(2, 12);
            endcase
            if (phase == 1)
                win = 127;
            else if (phase == 4)
                win = 2;
            write_window(CFG_W'(win));
            eff = (win == 0) ? 1 : (win > WIN_MAX) ? WIN_MAX : win;

            if (phase == 2 || phase == 4)
                span = eff - 1 + 80;
            else if ($urandom_range(0, 4) == 0)
                span = $urandom_range(0, eff - 1);
            else
                span = eff - 1 + $urandom_range(1, 40);

            // one stretch runs without any idling on either side
            gaps_on = (phase != 2);
            mode = $urandom_range(0, 5);
            fixed = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            for (int i = 0; i < span; i++) begin
                if (phase == 1)
                    pending_samples.push_back((i < WIN_MAX) ? 16'sh8000 : 16'sh7FFF);
                else if (mode == 0)
                    pending_samples.push_back(fixed);
                else
                    pending_samples.push_back(pick_sample());
            end
            items_planned += span;

            // receiver backs off while samples keep coming
            if (phase == 4) begin
                @(posedge i_clk);
                hold_request <= 1'b1;
                @(posedge i_clk);
                hold_request <= 1'b0;
                @(negedge i_clk);
            end
            phase++;
        end

        settle();
        $display("%0d samples over %0d window settings (1 to %0d, incl. zero and oversize)",
                 samples_sent, windows_set, WIN_MAX);
        $display("%0d averages checked, %0d mismatches, one %0d-cycle receiver hold-off",
                 avgs_checked, mismatches, HOLD_CYCLES);
        if (mismatches == 0)
            $display("** sliding_window_average: PASSED **");
        else
            $display("** sliding_window_average: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
